>>> design/contiguous_line_allocator_unit_macros.svh
// Assertion macros shared by the line allocator design files.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef CONTIGUOUS_LINE_ALLOCATOR_UNIT_MACROS_SVH
`define CONTIGUOUS_LINE_ALLOCATOR_UNIT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define CLAU_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The antecedent holding at one edge implies the consequent at the next.
`define CLAU_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> design/clau_pkg.sv
// Shared types and constants for the contiguous line allocator.
// Used by the hole picker and the top level of the block and by the testbench; it depends on nothing else.
package clau_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIT_POLICY   = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINES_IN_USE = 4'd1;

   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_WORST = 2'd1;
   localparam logic [1:0] POLICY_BEST  = 2'd2;

   localparam logic ACTION_ALLOC   = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   localparam logic [6:0] LINES_IN_USE_RESET = 7'd64;

   typedef struct packed {
      logic       action;
      logic [7:0] owner_id;
      logic [6:0] size_lines;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] start_line;
      logic [6:0] lines_released;
   } rsp_type;

   // Controls for the hole picker, one beat of the scan at a time.
   typedef struct packed {
      logic start;      // clear the picker for a new search
      logic step;       // one line's busy bit is presented
      logic line_busy;  // busy bit of the presented line
      logic close;      // close the hole still open after the last line
   } hole_ctl_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ASCAN,
      ST_ACLOSE,
      ST_APICK,
      ST_AWRITE,
      ST_RSCAN,
      ST_DONE
   } state_type;

endpackage

>>> design/clau_line_store.sv
// Busy bit and owner tag memories of the line allocator, one read port each.
// Depends on nothing but its parameters; read data is registered and appears in the cycle after the read.
module clau_line_store #(
   parameter int NUM_LINES  = 64,
   parameter int OWNER_BITS = 8,
   localparam int AW = $clog2(NUM_LINES)
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic                  busy_q,
   output logic [OWNER_BITS-1:0] owner_q,
   input  logic [AW-1:0]         wr_addr,
   input  logic                  busy_we,
   input  logic                  busy_d,
   input  logic                  owner_we,
   input  logic [OWNER_BITS-1:0] owner_d
);

   logic                  busy_mem  [NUM_LINES];
   logic [OWNER_BITS-1:0] owner_mem [NUM_LINES];

   always_ff @(posedge clock) begin
      if (busy_we) begin
         busy_mem[wr_addr] <= busy_d;
      end
      if (rd_en) begin
         busy_q <= busy_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[wr_addr] <= owner_d;
      end
      if (rd_en) begin
         owner_q <= owner_mem[rd_addr];
      end
   end

endmodule

>>> design/clau_hole_picker.sv
// Tracks free runs during an allocate scan and keeps the hole chosen by the policy.
// Depends on clau_pkg for the control struct and the policy codes.
module clau_hole_picker #(
   parameter int NUM_LINES = 64,
   localparam int AW = $clog2(NUM_LINES),
   localparam int LW = $clog2(NUM_LINES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  clau_pkg::hole_ctl_type ctl,
   input  logic [AW-1:0]         line_idx,
   input  logic [1:0]            policy,
   input  logic [6:0]            need,
   output logic                  found,
   output logic [AW-1:0]         pick_start
);

   localparam int CW = (LW > 7) ? LW : 7;

   logic          in_hole_ff, in_hole_in;
   logic [AW-1:0] hole_start_ff, hole_start_in;
   logic [LW-1:0] hole_len_ff, hole_len_in;
   logic          found_ff, found_in;
   logic [AW-1:0] pick_start_ff, pick_start_in;
   logic [LW-1:0] pick_len_ff, pick_len_in;
   logic          fits;
   logic          take;
   logic          closing;

   // The open hole is judged whenever a busy line or the end of the range closes it.
   assign closing = ctl.close || (ctl.step && ctl.line_busy);
   assign fits    = in_hole_ff && (CW'(hole_len_ff) >= CW'(need));
   assign take    = closing && fits &&
                    (!found_ff ||
                     ((policy == clau_pkg::POLICY_WORST) && (hole_len_ff > pick_len_ff)) ||
                     ((policy == clau_pkg::POLICY_BEST) && (hole_len_ff < pick_len_ff)));

   always_comb begin
      in_hole_in    = in_hole_ff;
      hole_start_in = hole_start_ff;
      hole_len_in   = hole_len_ff;
      found_in      = found_ff;
      pick_start_in = pick_start_ff;
      pick_len_in   = pick_len_ff;
      if (take) begin
         found_in      = 1'b1;
         pick_start_in = hole_start_ff;
         pick_len_in   = hole_len_ff;
      end
      priority if (ctl.start) begin
         in_hole_in = 1'b0;
         found_in   = 1'b0;
      end else if (closing) begin
         in_hole_in = 1'b0;
      end else if (ctl.step) begin
         if (in_hole_ff) begin
            hole_len_in = hole_len_ff + LW'(1);
         end else begin
            in_hole_in    = 1'b1;
            hole_start_in = line_idx;
            hole_len_in   = LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_hole_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         in_hole_ff <= in_hole_in;
         found_ff   <= found_in;
      end
      hole_start_ff <= hole_start_in;
      hole_len_ff   <= hole_len_in;
      pick_start_ff <= pick_start_in;
      pick_len_ff   <= pick_len_in;
   end

   assign found      = found_ff;
   assign pick_start = pick_start_ff;

endmodule

>>> design/contiguous_line_allocator_unit.sv
// Top level of the contiguous line allocator: sequencer, registers and result stage.
// Depends on clau_pkg, clau_line_store, clau_hole_picker and the assertion macros.
//
//   channel  direction  handshake              beat contents
//   req      in         req_valid / req_ready  action, owner_id, size_lines
//   rsp      out        rsp_valid / rsp_ready  ok, start_line, lines_released
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// An allocate reads the busy bit of each managed line to find the holes, then writes once per
// line of the run. A failed allocate skips the write, a zero size or an unused policy code
// skips the scan and goes straight to the result, and a release reads every line of the
// memory. The next request can be taken in the cycle after the result is loaded; only a
// result still waiting on rsp_ready stalls the sequencer. After reset the busy memory is
// cleared line by line, with req_ready held low.
`include "contiguous_line_allocator_unit_macros.svh"

module contiguous_line_allocator_unit #(
   parameter int NUM_LINES  = 64,
   parameter int OWNER_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  clau_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output clau_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [clau_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [clau_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int AW = $clog2(NUM_LINES);
   localparam int LW = $clog2(NUM_LINES + 1);
   localparam int CW = (LW > 7) ? LW : 7;

   clau_pkg::state_type state_ff, state_in;

   logic [1:0]            policy_ff;
   logic [6:0]            in_use_ff;
   clau_pkg::req_type     req_ff, req_in;
   logic [LW-1:0]         idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_idx_ff, pend_idx_in;
   logic [LW-1:0]         wcnt_ff, wcnt_in;
   logic                  ok_ff, ok_in;
   logic [AW-1:0]         start_ff, start_in;
   logic [LW-1:0]         freed_ff, freed_in;
   clau_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_fire;
   logic                  rsp_load;
   logic [CW-1:0]         in_use_ext;
   logic [LW-1:0]         n_lines;
   logic                  issue;
   logic                  scan_over;
   logic                  write_last;
   logic                  release_hit;
   logic [OWNER_BITS-1:0] tag;
   logic                  quick_fail;
   logic                  write_in_range;

   logic                  rd_en;
   logic [AW-1:0]         wr_addr;
   logic                  busy_we;
   logic                  busy_d;
   logic                  owner_we;
   logic                  busy_q;
   logic [OWNER_BITS-1:0] owner_q;

   clau_pkg::hole_ctl_type hole_ctl;
   logic                   hole_found;
   logic [AW-1:0]          hole_start;

   // Configuration is taken at any time; the register file is only two fields.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= clau_pkg::POLICY_FIRST;
         in_use_ff <= clau_pkg::LINES_IN_USE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            clau_pkg::CSR_FIT_POLICY:   policy_ff <= csr_data[1:0];
            clau_pkg::CSR_LINES_IN_USE: in_use_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // The managed count saturates at the size of the memory.
   assign in_use_ext = CW'(in_use_ff);
   assign n_lines    = (in_use_ext > CW'(NUM_LINES)) ? LW'(NUM_LINES) : LW'(in_use_ext);

   assign req_ready = (state_ff == clau_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The owner tag keeps only the low OWNER_BITS bits of the request field.
   assign tag = OWNER_BITS'(req_ff.owner_id);

   // A zero size or an unused policy code fails without touching the memories.
   assign quick_fail = (req_payload.size_lines == 7'd0) || (policy_ff > clau_pkg::POLICY_BEST);

   // A scan issues one read per cycle; the busy bit of that line is seen in the cycle after.
   always_comb begin
      unique case (state_ff)
         clau_pkg::ST_ASCAN: issue = (idx_ff < n_lines);
         clau_pkg::ST_RSCAN: issue = (idx_ff < LW'(NUM_LINES));
         default:            issue = 1'b0;
      endcase
   end

   assign scan_over   = !issue && !pend_ff;
   assign write_last  = (CW'(wcnt_ff) + CW'(1)) == CW'(req_ff.size_lines);
   assign release_hit = (state_ff == clau_pkg::ST_RSCAN) && pend_ff && busy_q &&
                        (owner_q == tag);
   assign rsp_load    = (state_ff == clau_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clau_pkg::ST_INIT: begin
            if (idx_ff == LW'(NUM_LINES - 1)) begin
               state_in = clau_pkg::ST_IDLE;
            end
         end
         clau_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (req_payload.action == clau_pkg::ACTION_RELEASE) begin
                  state_in = clau_pkg::ST_RSCAN;
               end else if (quick_fail) begin
                  state_in = clau_pkg::ST_DONE;
               end else begin
                  state_in = clau_pkg::ST_ASCAN;
               end
            end
         end
         clau_pkg::ST_ASCAN: begin
            if (scan_over) begin
               state_in = clau_pkg::ST_ACLOSE;
            end
         end
         clau_pkg::ST_ACLOSE: state_in = clau_pkg::ST_APICK;
         clau_pkg::ST_APICK: begin
            state_in = hole_found ? clau_pkg::ST_AWRITE : clau_pkg::ST_DONE;
         end
         clau_pkg::ST_AWRITE: begin
            if (write_last) begin
               state_in = clau_pkg::ST_DONE;
            end
         end
         clau_pkg::ST_RSCAN: begin
            if (scan_over) begin
               state_in = clau_pkg::ST_DONE;
            end
         end
         clau_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = clau_pkg::ST_IDLE;
            end
         end
         default: state_in = clau_pkg::ST_IDLE;
      endcase
   end

   // Memory port and hole picker controls.
   always_comb begin
      rd_en    = issue;
      wr_addr  = idx_ff[AW-1:0];
      busy_we  = 1'b0;
      busy_d   = 1'b0;
      owner_we = 1'b0;
      hole_ctl = '0;
      unique case (state_ff)
         clau_pkg::ST_INIT: begin
            busy_we = 1'b1;
         end
         clau_pkg::ST_IDLE: begin
            hole_ctl.start = req_fire;
         end
         clau_pkg::ST_ASCAN: begin
            hole_ctl.step      = pend_ff;
            hole_ctl.line_busy = busy_q;
         end
         clau_pkg::ST_ACLOSE: begin
            hole_ctl.close = 1'b1;
         end
         clau_pkg::ST_AWRITE: begin
            wr_addr  = start_ff + wcnt_ff[AW-1:0];
            busy_we  = 1'b1;
            busy_d   = 1'b1;
            owner_we = 1'b1;
         end
         clau_pkg::ST_RSCAN: begin
            wr_addr = pend_idx_ff;
            busy_we = release_hit;
         end
         default: ;
      endcase
   end

   // Counters and result fields.
   always_comb begin
      req_in       = req_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = idx_ff[AW-1:0];
      wcnt_in      = wcnt_ff;
      ok_in        = ok_ff;
      start_in     = start_ff;
      freed_in     = freed_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == clau_pkg::ST_INIT) begin
         idx_in = idx_ff + LW'(1);
      end
      if (req_fire) begin
         req_in   = req_payload;
         idx_in   = '0;
         wcnt_in  = '0;
         ok_in    = (req_payload.action == clau_pkg::ACTION_RELEASE);
         start_in = '0;
         freed_in = '0;
      end
      if (issue) begin
         pend_in = 1'b1;
         idx_in  = idx_ff + LW'(1);
      end
      if (release_hit) begin
         freed_in = freed_ff + LW'(1);
      end
      if (state_ff == clau_pkg::ST_APICK) begin
         ok_in    = hole_found;
         start_in = hole_found ? hole_start : '0;
      end
      if (state_ff == clau_pkg::ST_AWRITE) begin
         wcnt_in = wcnt_ff + LW'(1);
      end
      if (rsp_load) begin
         rsp_in.ok             = ok_ff;
         rsp_in.start_line     = 6'(start_ff);
         rsp_in.lines_released = 7'(freed_ff);
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clau_pkg::ST_INIT;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      pend_idx_ff <= pend_idx_in;
      wcnt_ff     <= wcnt_in;
      ok_ff       <= ok_in;
      start_ff    <= start_in;
      freed_ff    <= freed_in;
      rsp_ff      <= rsp_in;
   end

   clau_line_store #(
      .NUM_LINES  (NUM_LINES),
      .OWNER_BITS (OWNER_BITS)
   ) u_store (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (idx_ff[AW-1:0]),
      .busy_q   (busy_q),
      .owner_q  (owner_q),
      .wr_addr  (wr_addr),
      .busy_we  (busy_we),
      .busy_d   (busy_d),
      .owner_we (owner_we),
      .owner_d  (tag)
   );

   clau_hole_picker #(
      .NUM_LINES (NUM_LINES)
   ) u_picker (
      .clock      (clock),
      .reset      (reset),
      .ctl        (hole_ctl),
      .line_idx   (pend_idx_ff),
      .policy     (policy_ff),
      .need       (req_ff.size_lines),
      .found      (hole_found),
      .pick_start (hole_start)
   );

   // The granted run must lie inside the managed lines.
   assign write_in_range = (state_ff != clau_pkg::ST_AWRITE) || (LW'(wr_addr) < n_lines);
   `CLAU_ASSERT_ALWAYS(a_write_in_range, write_in_range, "allocation write outside the lines")
   // An accepted request always leaves the idle state.
   `CLAU_ASSERT_NEXT(a_fire_leaves_idle, req_fire, !req_ready, "sequencer stayed idle")
   // A loaded result is presented on the next cycle.
   `CLAU_ASSERT_NEXT(a_load_shows, rsp_load, rsp_valid_ff, "result loaded but not presented")
   // A release never frees more lines than the memory holds.
   `CLAU_ASSERT_ALWAYS(a_freed_bound, freed_ff <= LW'(NUM_LINES), "freed count too large")

endmodule

>>> tb/line_allocator_checker.sv
`timescale 1ns / 1ps
// Checker for the contiguous line allocator: watches the request, result and register
// channels, keeps its own line map and compares every result beat. Depends on clau_pkg.
module line_allocator_checker #(
   parameter int NUM_LINES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  clau_pkg::req_type                   req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  clau_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [clau_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [clau_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int unsigned                         outstanding,
   output int unsigned                         accepted_requests,
   output int unsigned                         failures
);
   import clau_pkg::*;

   logic       line_taken [NUM_LINES];
   logic [7:0] line_tag   [NUM_LINES];
   logic [1:0] cfg_policy;
   logic [6:0] cfg_lines;

   rsp_type     awaited_results [$];
   int unsigned mismatch_count;
   int unsigned request_count;

   initial begin
      foreach (line_taken[i]) begin
         line_taken[i] = 1'b0;
         line_tag[i]   = '0;
      end
      cfg_policy        = POLICY_FIRST;
      cfg_lines         = LINES_IN_USE_RESET;
      mismatch_count    = 0;
      request_count     = 0;
      outstanding       = 0;
      accepted_requests = 0;
      failures          = 0;
   end

   // Updates the line map for one request and returns the result it must produce.
   function automatic rsp_type allocate_or_release(input req_type r);
      rsp_type res;
      int      managed, i, hole_start, hole_len, pick_start, pick_len, freed, need;
      bit      found;
      res = '0;
      need = int'(r.size_lines);
      freed = 0;
      if (r.action == ACTION_RELEASE) begin
         // A release looks at every line, managed or not.
         for (i = 0; i < NUM_LINES; i++) begin
            if (line_taken[i] && line_tag[i] == r.owner_id) begin
               line_taken[i] = 1'b0;
               freed++;
            end
         end
         res.ok = 1'b1;
         res.lines_released = freed[6:0];
      end else if (need != 0 && (cfg_policy == POLICY_FIRST || cfg_policy == POLICY_WORST ||
                                 cfg_policy == POLICY_BEST)) begin
         managed = (int'(cfg_lines) > NUM_LINES) ? NUM_LINES : int'(cfg_lines);
         found = 1'b0;
         pick_start = 0;
         pick_len = 0;
         i = 0;
         while (i < managed) begin
            if (line_taken[i]) begin
               i++;
            end else begin
               hole_start = i;
               while (i < managed && !line_taken[i])
                  i++;
               hole_len = i - hole_start;
               if (hole_len >= need) begin
                  if (!found) begin
                     found = 1'b1;
                     pick_start = hole_start;
                     pick_len = hole_len;
                     if (cfg_policy == POLICY_FIRST)
                        break;
                  end else if (cfg_policy == POLICY_WORST && hole_len > pick_len) begin
                     pick_start = hole_start;
                     pick_len = hole_len;
                  end else if (cfg_policy == POLICY_BEST && hole_len < pick_len) begin
                     pick_start = hole_start;
                     pick_len = hole_len;
                  end
               end
            end
         end
         if (found) begin
            for (i = 0; i < need; i++) begin
               line_taken[pick_start + i] = 1'b1;
               line_tag[pick_start + i]   = r.owner_id;
            end
            res.ok = 1'b1;
            res.start_line = pick_start[5:0];
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: result beat expected none, got %p", $time, rsp_payload);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("ok", 7'(want.ok), 7'(rsp_payload.ok));
               check_field("start_line", 7'(want.start_line), 7'(rsp_payload.start_line));
               check_field("lines_released", want.lines_released, rsp_payload.lines_released);
            end
         end
         if (req_valid && req_ready) begin
            awaited_results.push_back(allocate_or_release(req_payload));
            request_count++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FIT_POLICY)
               cfg_policy = csr_data[1:0];
            else if (csr_index == CSR_LINES_IN_USE)
               cfg_lines = csr_data[6:0];
         end
      end
      outstanding       <= awaited_results.size();
      accepted_requests <= request_count;
      failures          <= mismatch_count;
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the line allocator testbench: clock, reset, request and register stimulus, verdict.
// Depends on clau_pkg, contiguous_line_allocator_unit and line_allocator_checker.
module testbench;
   import clau_pkg::*;

   localparam int NUM_LINES       = 64;
   localparam int OWNER_BITS      = 8;
   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_BEATS     = 55;
   // The long receiver hold-off starts once this many request beats have gone in, which
   // falls in the middle of the third random phase, while the sender is still busy.
   localparam int HOLD_OFF_AT     = 160;
   localparam int HOLD_OFF_CYCLES = 400;
   // Long enough to cover one more full allocate over all 64 lines.
   localparam int SETTLE_CYCLES   = 200;
   // The limit leaves ample headroom over the slowest correct run.
   localparam int CYCLE_LIMIT     = 400000;
   // Policy code that selects no algorithm; every allocate must fail under it.
   localparam logic [1:0] POLICY_UNUSED = 2'd3;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   rsp_type                   rsp_payload;
   logic                      csr_valid   = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data    = '0;

   int unsigned outstanding;
   int unsigned accepted_requests;
   int unsigned failures;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;

   always #5 clock = ~clock;

   contiguous_line_allocator_unit #(
      .NUM_LINES  (NUM_LINES),
      .OWNER_BITS (OWNER_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   line_allocator_checker #(
      .NUM_LINES (NUM_LINES)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .outstanding       (outstanding),
      .accepted_requests (accepted_requests),
      .failures          (failures)
   );

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_type make_request(input logic act, input logic [7:0] owner,
                                            input logic [6:0] size);
      req_type r;
      r.action     = act;
      r.owner_id   = owner;
      r.size_lines = size;
      return r;
   endfunction

   // Offers one request beat and returns at the edge where it is taken. The sender works
   // in bursts: when a burst runs out, valid drops for a random gap (sometimes none at all)
   // and a new burst length is drawn. Valid is never lowered while a beat is on offer.
   task automatic offer(input req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering and waits until every expected result beat has come back. Each request
   // yields exactly one result, so the block is idle once nothing is outstanding.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Writes both registers in two back-to-back beats; valid stays high between them.
   task automatic apply_settings(input logic [CSR_DATA_BITS-1:0] policy_data,
                                 input logic [CSR_DATA_BITS-1:0] lines_data);
      csr_valid <= 1'b1;
      csr_index <= CSR_FIT_POLICY;
      csr_data  <= policy_data;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_LINES_IN_USE;
      csr_data  <= lines_data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Result side: the receiver changes its stall pattern every so often, from always ready
   // to mostly stalled. Once, in mid-run, it holds off for a long stretch so that the result
   // register and the request in flight back up and the block stops taking requests.
   initial begin
      int unsigned mode, span, k;
      bit          held_off;
      held_off = 1'b0;
      wait (reset == 1'b0);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         for (k = 0; k < span; k++) begin
            @(posedge clock);
            if (!held_off && accepted_requests >= HOLD_OFF_AT) begin
               held_off = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
            end
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Request side and verdict.
   initial begin
      req_type     item;
      int unsigned phase, beat, roll;
      logic [7:0]  policy_data, lines_data;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first fit over all 64 lines. The whole array goes to one owner, then
      // nothing fits; the release frees all 64. A zero size and an oversized request fail,
      // and releasing an owner that holds nothing still succeeds with nothing freed.
      apply_settings(8'(POLICY_FIRST), 8'd64);
      offer(make_request(ACTION_ALLOC, 8'hFF, 7'd64));
      offer(make_request(ACTION_ALLOC, 8'h01, 7'd1));
      offer(make_request(ACTION_RELEASE, 8'hFF, 7'd0));
      offer(make_request(ACTION_ALLOC, 8'h00, 7'd0));
      offer(make_request(ACTION_ALLOC, 8'h02, 7'h7F));
      offer(make_request(ACTION_RELEASE, 8'h09, 7'h7F));

      // Carve the lines so that three holes remain: two lines at 4, one line at 14 and the
      // rest from 18 upwards. Each policy then places a one-line run somewhere different.
      offer(make_request(ACTION_ALLOC, 8'h01, 7'd4));
      offer(make_request(ACTION_ALLOC, 8'h02, 7'd2));
      offer(make_request(ACTION_ALLOC, 8'h03, 7'd8));
      offer(make_request(ACTION_ALLOC, 8'h04, 7'd1));
      offer(make_request(ACTION_ALLOC, 8'h05, 7'd3));
      offer(make_request(ACTION_RELEASE, 8'h02, 7'd0));
      offer(make_request(ACTION_RELEASE, 8'h04, 7'd0));
      offer(make_request(ACTION_ALLOC, 8'h06, 7'd1));
      drain();
      apply_settings(8'(POLICY_WORST), 8'd64);
      offer(make_request(ACTION_ALLOC, 8'h07, 7'd1));
      drain();
      apply_settings(8'(POLICY_BEST), 8'd64);
      offer(make_request(ACTION_ALLOC, 8'h07, 7'd1));

      // The unused policy code and a managed count of zero both refuse every allocate.
      drain();
      apply_settings(8'(POLICY_UNUSED), 8'd64);
      offer(make_request(ACTION_ALLOC, 8'h08, 7'd1));
      drain();
      apply_settings(8'(POLICY_FIRST), 8'd0);
      offer(make_request(ACTION_ALLOC, 8'h09, 7'd1));

      // An all-ones count saturates to the full array.
      drain();
      apply_settings(8'(POLICY_FIRST), 8'hFF);
      offer(make_request(ACTION_ALLOC, 8'h0A, 7'd45));
      offer(make_request(ACTION_RELEASE, 8'h07, 7'd0));
      offer(make_request(ACTION_RELEASE, 8'hFF, 7'd0));

      // Random part, one phase per setting. The state carries over from phase to phase, so
      // lowering the managed count leaves busy lines beyond it that only a release can free.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin policy_data = 8'(POLICY_FIRST);  lines_data = 8'd64;  end
            1: begin policy_data = 8'(POLICY_WORST);  lines_data = 8'd64;  end
            2: begin policy_data = 8'(POLICY_BEST);   lines_data = 8'd64;  end
            3: begin policy_data = 8'(POLICY_BEST);   lines_data = 8'd24;  end
            4: begin policy_data = 8'hFD;             lines_data = 8'd1;   end
            5: begin policy_data = 8'(POLICY_FIRST);  lines_data = 8'd100; end
            6: begin policy_data = 8'(POLICY_UNUSED); lines_data = 8'd40;  end
            default: begin policy_data = 8'(POLICY_BEST); lines_data = 8'd64; end
         endcase
         drain();
         apply_settings(policy_data, lines_data);
         for (beat = 0; beat < PHASE_BEATS; beat++) begin
            // Mostly a small pool of owners with small runs, so that holes of many sizes
            // open and close; now and then any owner tag, and the odd size out of range.
            item.action   = ($urandom_range(0, 99) < 30) ? ACTION_RELEASE : ACTION_ALLOC;
            item.owner_id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 7));
            roll = $urandom_range(0, 99);
            if (roll < 70)
               item.size_lines = 7'($urandom_range(1, 6));
            else if (roll < 90)
               item.size_lines = 7'($urandom_range(7, 24));
            else if (roll < 95)
               item.size_lines = 7'($urandom_range(25, 64));
            else if (roll < 97)
               item.size_lines = 7'd0;
            else
               item.size_lines = 7'($urandom_range(65, 127));
            offer(item);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
